// ===== src/btmx_pkg.sv =====
// Package for the binary trie min-xor unit: shared constants, op and status codes.
// No dependencies.
`default_nettype none
package btmx_pkg;
  localparam int unsigned KEY_BITS_DEF = 30;
  localparam int unsigned NODE_CAP_DEF = 65536;
  localparam int unsigned CNT_W = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_BAD    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_MISS  = 2'd1,
    ST_SPACE = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;
endpackage
`default_nettype wire

// ===== src/btmx_if.sv =====
// Valid/ready channel interfaces for the trie unit.
// Depends on nothing; key and element widths come from parameters.
`default_nettype none
interface btmx_in_if #(parameter int unsigned KB = 30) (input wire logic clk);
  logic          valid;
  logic          ready;
  logic [1:0]    op;
  logic [KB-1:0] key;
  modport source (output valid, op, key, input ready);
  modport sink   (input valid, op, key, output ready);
endinterface

interface btmx_out_if #(parameter int unsigned KB = 30) (input wire logic clk);
  logic          valid;
  logic          ready;
  logic [1:0]    status;
  logic [KB-1:0] element;
  logic [31:0]   element_count;
  modport source (output valid, status, element, element_count, input ready);
  modport sink   (input valid, status, element, element_count, output ready);
endinterface

interface btmx_cfg_if (input wire logic clk);
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== src/btmx_node_mem.sv =====
// Node pool memory: zero link, one link and subtree count per node.
// One write port, one registered read port. No dependencies.
`default_nettype none
module btmx_node_mem #(
  parameter int unsigned AW = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [AW-1:0] wz,
  input  wire logic [AW-1:0] wo,
  input  wire logic [31:0]   wc,
  input  wire logic [AW-1:0] raddr,
  output logic      [AW-1:0] rz,
  output logic      [AW-1:0] ro,
  output logic      [31:0]   rc
);
  logic [AW+AW+31:0] mem [2**AW];
  logic [AW+AW+31:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wz, wo, wc};
    end
    rd_r <= mem[raddr];
  end

  assign rz = rd_r[AW+AW+31:AW+32];
  assign ro = rd_r[AW+31:32];
  assign rc = rd_r[31:0];
endmodule
`default_nettype wire

// ===== src/binary_trie_min_xor_unit.sv =====
// Top level of the binary trie min-xor unit: sequencer over one node memory.
// Depends on btmx_pkg, btmx_if.sv and btmx_node_mem.
//
//  channel | dir | handshake     | payload
//  in_     | in  | valid/ready   | op[1:0], key[KEY_BITS-1:0]
//  out_    | out | valid/ready   | status[1:0], element[KEY_BITS-1:0], element_count[31:0]
//  cfg_    | in  | valid/ready   | data (allow_duplicates)
//
// Every memory read passes through S_RD and its data is used in the next evaluate cycle.
// Insert and remove walk twice: a check walk (evaluate + read per level, one leaf check) and
// an update walk (evaluate/write + read per level, one leaf write). Each node allocated on
// the update walk skips its read. A query reads the preferred child at each level, plus a
// read of the other side when that child is empty. An empty-trie query or an undefined op
// goes from S_IDLE straight to S_OUT. The single memory read port sets this sequencing.
// Reset is synchronous; the root lives in registers and a node is written when allocated,
// so no clearing pass is needed. in_ready is high only in S_IDLE; the result is held in
// S_OUT until taken and the next item waits for that.
`default_nettype none
module binary_trie_min_xor_unit #(
  parameter int unsigned KEY_BITS      = btmx_pkg::KEY_BITS_DEF,
  parameter int unsigned NODE_CAPACITY = btmx_pkg::NODE_CAP_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  btmx_in_if.sink   in_ch,
  btmx_out_if.source out_ch,
  btmx_cfg_if.sink  cfg_ch
);
  localparam int unsigned AW = $clog2(NODE_CAPACITY);
  localparam int unsigned LW = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int unsigned FW = AW + 1;
  localparam int unsigned PW = FW + 1;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RD   = 8'b0000_0010,  // read issued for node_r
    S_CHK  = 8'b0000_0100,  // check walk, one level
    S_LEAF = 8'b0000_1000,  // check walk, leaf count back
    S_UPD  = 8'b0001_0000,  // update walk: write node with new count / link
    S_QRY1 = 8'b0010_0000,  // query: pick preferred child
    S_QRY2 = 8'b0100_0000,  // query: preferred child's count back
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t              state_r, ret_r;
  logic                dup_r;
  logic [1:0]          op_r;
  logic [KEY_BITS-1:0] key_r;
  logic [KEY_BITS-1:0] res_r;
  logic [LW-1:0]       lvl_r;
  logic                leaf_r;
  logic [AW-1:0]       node_r, alt_r;
  logic [FW-1:0]       free_r;
  logic [AW-1:0]       rootz_r, rooto_r;
  logic [31:0]         rootc_r;
  logic [AW-1:0]       curz_r, curo_r;
  logic [31:0]         curc_r;
  logic                mem_sel_r;
  logic [1:0]          ost_r;

  // memory wiring
  logic          we;
  logic [AW-1:0] wz, wo, rz, ro;
  logic [31:0]   wc, rc;

  btmx_node_mem #(.AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(node_r), .wz(wz), .wo(wo), .wc(wc),
    .raddr(node_r), .rz(rz), .ro(ro), .rc(rc)
  );

  // current node's fields: memory data right after a read, else the held copy
  logic [AW-1:0]       cz, co, child, alt, newn;
  logic [31:0]         cc, cnt_upd;
  logic                kb, ins_op, need_new, last_lvl, pool_short;
  logic [KEY_BITS-1:0] res_kb, res_flip;

  assign cz       = mem_sel_r ? rz : curz_r;
  assign co       = mem_sel_r ? ro : curo_r;
  assign cc       = mem_sel_r ? rc : curc_r;
  assign kb       = key_r[lvl_r];
  assign child    = kb ? co : cz;
  assign alt      = kb ? cz : co;
  assign ins_op   = (op_r == btmx_pkg::OP_INSERT);
  assign cnt_upd  = ins_op ? cc + 32'd1 : cc - 32'd1;
  assign need_new = ins_op && !leaf_r && (child == '0);
  assign newn     = free_r[AW-1:0];
  assign last_lvl = (lvl_r == '0);
  // nodes still needed from this level down: lvl_r + 1
  assign pool_short = ({1'b0, free_r} + PW'(lvl_r) + PW'(1)) > PW'(NODE_CAPACITY);

  always_comb begin
    res_kb           = res_r;
    res_kb[lvl_r]    = kb;
    res_flip         = res_r;
    res_flip[lvl_r]  = ~kb;
  end

  // root links and count live in registers; every other node goes to memory
  assign we = (state_r == S_UPD) && (node_r != '0);
  always_comb begin
    wz = cz; wo = co; wc = cnt_upd;
    if (need_new) begin
      if (kb) wo = newn; else wz = newn;
    end
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign cfg_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid         = (state_r == S_OUT);
  assign out_ch.status        = ost_r;
  assign out_ch.element       = res_r;
  assign out_ch.element_count = rootc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ret_r <= S_IDLE; dup_r <= 1'b1; free_r <= FW'(1);
      rootz_r <= '0; rooto_r <= '0; rootc_r <= '0; mem_sel_r <= 1'b0;
      op_r <= '0; key_r <= '0; res_r <= '0; lvl_r <= '0; leaf_r <= 1'b0;
      node_r <= '0; alt_r <= '0; curz_r <= '0; curo_r <= '0; curc_r <= '0;
      ost_r <= btmx_pkg::ST_DONE;
    end else begin
      mem_sel_r <= (state_r == S_RD);
      if (cfg_ch.valid && cfg_ch.ready) dup_r <= cfg_ch.data;
      unique case (state_r)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          op_r <= in_ch.op; key_r <= in_ch.key; res_r <= '0; node_r <= '0;
          lvl_r <= LW'(KEY_BITS - 1); leaf_r <= 1'b0;
          curz_r <= rootz_r; curo_r <= rooto_r; curc_r <= rootc_r;
          if (in_ch.op inside {btmx_pkg::OP_INSERT, btmx_pkg::OP_REMOVE}) begin
            ost_r <= btmx_pkg::ST_DONE; state_r <= S_CHK;
          end else if (in_ch.op == btmx_pkg::OP_QUERY) begin
            // empty trie answers element 0 at once
            ost_r <= btmx_pkg::ST_DONE;
            state_r <= (rootc_r == '0) ? S_OUT : S_QRY1;
          end else begin
            ost_r <= btmx_pkg::ST_MISS; state_r <= S_OUT;
          end
        end
        S_RD: state_r <= ret_r;
        S_CHK: begin
          if (child == '0) begin
            if (!ins_op) begin
              ost_r <= btmx_pkg::ST_MISS; state_r <= S_OUT;
            end else if (pool_short || rootc_r == '1) begin
              ost_r <= btmx_pkg::ST_SPACE; state_r <= S_OUT;
            end else begin
              node_r <= '0; lvl_r <= LW'(KEY_BITS - 1); leaf_r <= 1'b0;
              curz_r <= rootz_r; curo_r <= rooto_r; curc_r <= rootc_r;
              state_r <= S_UPD;
            end
          end else begin
            node_r <= child; state_r <= S_RD;
            if (last_lvl) begin
              ret_r <= S_LEAF;
            end else begin
              lvl_r <= lvl_r - LW'(1); ret_r <= S_CHK;
            end
          end
        end
        S_LEAF: begin
          // cc is the leaf count, i.e. the key's multiplicity
          if (ins_op ? (!dup_r && cc != '0) : (cc == '0)) begin
            ost_r <= btmx_pkg::ST_MISS; state_r <= S_OUT;
          end else if (ins_op && rootc_r == '1) begin
            ost_r <= btmx_pkg::ST_SPACE; state_r <= S_OUT;
          end else begin
            node_r <= '0; lvl_r <= LW'(KEY_BITS - 1); leaf_r <= 1'b0;
            curz_r <= rootz_r; curo_r <= rooto_r; curc_r <= rootc_r;
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (leaf_r) begin
            // leaf count goes to memory this cycle
            state_r <= S_OUT;
          end else begin
            if (node_r == '0) begin
              rootc_r <= cnt_upd;
              if (need_new) begin
                if (kb) rooto_r <= newn; else rootz_r <= newn;
              end
            end
            if (last_lvl) leaf_r <= 1'b1; else lvl_r <= lvl_r - LW'(1);
            if (need_new) begin
              // fresh node starts empty: no read needed
              free_r <= free_r + FW'(1);
              node_r <= newn; curz_r <= '0; curo_r <= '0; curc_r <= '0;
            end else begin
              node_r <= child; ret_r <= S_UPD; state_r <= S_RD;
            end
          end
        end
        S_QRY1: begin
          if (child != '0) begin
            alt_r <= alt; node_r <= child; ret_r <= S_QRY2; state_r <= S_RD;
          end else begin
            res_r <= res_flip;
            if (alt == '0 || last_lvl) begin
              state_r <= S_OUT;
            end else begin
              node_r <= alt; lvl_r <= lvl_r - LW'(1); ret_r <= S_QRY1; state_r <= S_RD;
            end
          end
        end
        S_QRY2: begin
          if (cc != '0) begin
            // preferred child holds elements: keep its record and descend
            res_r <= res_kb;
            if (last_lvl) begin
              state_r <= S_OUT;
            end else begin
              curz_r <= cz; curo_r <= co; curc_r <= cc;
              lvl_r <= lvl_r - LW'(1); state_r <= S_QRY1;
            end
          end else begin
            res_r <= res_flip;
            if (alt_r == '0 || last_lvl) begin
              state_r <= S_OUT;
            end else begin
              node_r <= alt_r; lvl_r <= lvl_r - LW'(1); ret_r <= S_QRY1; state_r <= S_RD;
            end
          end
        end
        S_OUT: if (out_ch.valid && out_ch.ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.status) &&
      $stable(out_ch.element) && $stable(out_ch.element_count))
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n) free_r <= FW'(NODE_CAPACITY))
    else $error("pool overrun");
  assert property (@(posedge clk) disable iff (!rst_n) state_r != S_IDLE |-> !in_ch.ready)
    else $error("ready while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && op_r != btmx_pkg::OP_QUERY |-> out_ch.element == '0)
    else $error("element set on non-query");
endmodule
`default_nettype wire

// ===== test/binary_trie_min_xor_unit_test.sv =====
// Self-checking bench for binary_trie_min_xor_unit: random and directed insert, remove and
// query items checked against a behavioral trie predictor kept as a sorted multiset.
// Depends on btmx_pkg and the channel interfaces in src/btmx_if.sv.
`default_nettype none
module binary_trie_min_xor_unit_test;
  localparam int unsigned KB = btmx_pkg::KEY_BITS_DEF;
  localparam int unsigned NODE_CAP = btmx_pkg::NODE_CAP_DEF;
  localparam int unsigned LIMIT = 2000000;

  typedef struct packed {
    btmx_pkg::op_t op;
    logic [KB-1:0] key;
  } trie_item_t;

  typedef struct packed {
    btmx_pkg::status_t status;
    logic [KB-1:0]     element;
    logic [31:0]       element_count;
  } trie_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  btmx_in_if #(.KB(KB)) in_ch (clk);
  btmx_out_if #(.KB(KB)) out_ch (clk);
  btmx_cfg_if cfg_ch (clk);

  binary_trie_min_xor_unit u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Predictor state: key multiplicities, the set of trie prefixes that own a node,
  // and the node allocation pointer (nodes are never freed).
  int unsigned key_mult[logic [KB-1:0]];
  bit node_used[logic [KB:0]];
  int unsigned nodes_taken;
  logic [31:0] total_elems;
  bit dup_ok;

  trie_item_t pending_items[$];
  trie_result_t expected_results[$];

  int unsigned send_idle_pct, recv_stall_pct;
  bit send_hold;
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  bit failed;

  // Node id for the prefix of key that covers level lvl and above: tag with a leading one.
  function automatic logic [KB:0] prefix_tag(logic [KB-1:0] key, int lvl);
    logic [KB:0] tagged_key;
    tagged_key = {1'b1, key};
    return tagged_key >> lvl;
  endfunction

  // Count new nodes that inserting key would allocate.
  function automatic int unsigned missing_nodes(logic [KB-1:0] key);
    int unsigned miss;
    miss = 0;
    for (int lvl = KB - 1; lvl >= 0; lvl--)
      if (!node_used.exists(prefix_tag(key, lvl))) miss++;
    return miss;
  endfunction

  // Subtree count under a node prefix: sum of multiplicities of keys sharing it.
  function automatic int unsigned subtree_elems(logic [KB:0] tag, int lvl);
    int unsigned sum;
    sum = 0;
    foreach (key_mult[k])
      if (prefix_tag(k, lvl) == tag) sum += key_mult[k];
    return sum;
  endfunction

  // Greedy trie walk: prefer the matching bit where that child exists with a nonzero count.
  function automatic logic [KB-1:0] min_xor_element(logic [KB-1:0] key);
    logic [KB-1:0] res;
    logic b;
    logic [KB-1:0] cand;
    res = '0;
    for (int lvl = KB - 1; lvl >= 0; lvl--) begin
      b = key[lvl];
      cand = res;
      cand[lvl] = b;
      if (!node_used.exists(prefix_tag(cand, lvl)) ||
          subtree_elems(prefix_tag(cand, lvl), lvl) == 0)
        b = ~b;
      res[lvl] = b;
      cand = res;
      if (!node_used.exists(prefix_tag(cand, lvl))) break;
    end
    return res;
  endfunction

  function automatic trie_result_t predict_result(trie_item_t it);
    trie_result_t r;
    int unsigned miss;
    r.status = btmx_pkg::ST_MISS;
    r.element = '0;
    case (it.op)
      btmx_pkg::OP_INSERT: begin
        miss = missing_nodes(it.key);
        if (miss == 0 && !dup_ok && key_mult.exists(it.key) && key_mult[it.key] != 0)
          r.status = btmx_pkg::ST_MISS;
        else if (nodes_taken + miss > NODE_CAP || total_elems == 32'hFFFF_FFFF)
          r.status = btmx_pkg::ST_SPACE;
        else begin
          for (int lvl = KB - 1; lvl >= 0; lvl--) node_used[prefix_tag(it.key, lvl)] = 1'b1;
          nodes_taken += miss;
          if (!key_mult.exists(it.key)) key_mult[it.key] = 0;
          key_mult[it.key]++;
          total_elems++;
          r.status = btmx_pkg::ST_DONE;
        end
      end
      btmx_pkg::OP_REMOVE: begin
        if (key_mult.exists(it.key) && key_mult[it.key] != 0) begin
          key_mult[it.key]--;
          total_elems--;
          r.status = btmx_pkg::ST_DONE;
        end
      end
      btmx_pkg::OP_QUERY: begin
        r.status = btmx_pkg::ST_DONE;
        if (total_elems != 0) r.element = min_xor_element(it.key);
      end
      default: r.status = btmx_pkg::ST_MISS;
    endcase
    r.element_count = total_elems;
    return r;
  endfunction

  // Driver: advance to the next pending item after each accepted one. With send_hold set,
  // hold until every expected result has come back.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.op <= btmx_pkg::OP_INSERT;
      in_ch.key <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_items.size() != 0 && !(send_hold && expected_results.size() != 0) &&
          $urandom_range(99) >= send_idle_pct) begin
        trie_item_t it;
        it = pending_items.pop_front();
        expected_results.push_back(predict_result(it));
        in_ch.valid <= 1'b1;
        in_ch.op <= it.op;
        in_ch.key <= it.key;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted result against the oldest expectation; stall at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        trie_result_t want;
        if (expected_results.size() == 0) begin
          failed = 1'b1;
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("unexpected result status=%0d", out_ch.status);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.status !== want.status || out_ch.element !== want.element ||
              out_ch.element_count !== want.element_count) begin
            failed = 1'b1;
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: exp st=%0d el=%h cnt=%0d got st=%0d el=%h cnt=%0d",
                       want.status, want.element, want.element_count,
                       out_ch.status, out_ch.element, out_ch.element_count);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: drop the run at the cycle limit.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic queue_item(btmx_pkg::op_t op, logic [KB-1:0] key);
    trie_item_t it;
    it.op = op;
    it.key = key;
    pending_items.push_back(it);
  endtask

  // Hold until every queued item has been sent and every result has arrived.
  task automatic drain();
    while (pending_items.size() != 0 || expected_results.size() != 0 || in_ch.valid)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_dup_mode(bit val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    dup_ok = val;
  endtask

  // Random key from a small pool so removes and duplicates hit, with some wide keys.
  function automatic logic [KB-1:0] pick_key(logic [KB-1:0] pool[$]);
    logic [KB-1:0] k;
    if ($urandom_range(3) == 0) k = KB'($urandom);
    else begin
      k = pool[$urandom_range(pool.size() - 1)];
      if ($urandom_range(3) == 0) k[$urandom_range(KB - 1)] ^= 1'b1;
    end
    return k;
  endfunction

  task automatic random_phase(int n, int unsigned idle, int unsigned stall);
    logic [KB-1:0] pool[$];
    int unsigned sel;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < 16; i++) pool.push_back(KB'($urandom));
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 40) queue_item(btmx_pkg::OP_INSERT, pick_key(pool));
      else if (sel < 65) queue_item(btmx_pkg::OP_REMOVE, pick_key(pool));
      else if (sel < 97) queue_item(btmx_pkg::OP_QUERY, KB'($urandom));
      else queue_item(btmx_pkg::OP_BAD, KB'($urandom));
    end
    drain();
  endtask

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.data = 1'b0;
    dup_ok = 1'b1;
    nodes_taken = 1;
    total_elems = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_hold = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty query, extremes, duplicates, absent remove, undefined op.
    queue_item(btmx_pkg::OP_QUERY, '1);
    queue_item(btmx_pkg::OP_REMOVE, '0);
    queue_item(btmx_pkg::OP_INSERT, '0);
    queue_item(btmx_pkg::OP_INSERT, '1);
    queue_item(btmx_pkg::OP_INSERT, '1);
    queue_item(btmx_pkg::OP_QUERY, '1);
    queue_item(btmx_pkg::OP_QUERY, 30'h1FFF_FFFF);
    queue_item(btmx_pkg::OP_QUERY, 30'h2000_0000);
    queue_item(btmx_pkg::OP_REMOVE, '1);
    queue_item(btmx_pkg::OP_QUERY, '1);
    queue_item(btmx_pkg::OP_BAD, 30'h1555_5555);
    queue_item(btmx_pkg::OP_INSERT, 30'h2AAA_AAAA);
    queue_item(btmx_pkg::OP_QUERY, 30'h1555_5555);
    queue_item(btmx_pkg::OP_REMOVE, 30'h1555_5555);
    drain();

    // Set mode: second insert of a stored key is rejected.
    write_dup_mode(1'b0);
    queue_item(btmx_pkg::OP_INSERT, '0);
    queue_item(btmx_pkg::OP_INSERT, 30'h0000_0001);
    queue_item(btmx_pkg::OP_QUERY, 30'h0000_0003);
    drain();

    random_phase(110, 0, 0);
    // Sender pauses until every expected result has come back before each item.
    send_hold = 1'b1;
    for (int i = 0; i < 4; i++) queue_item(btmx_pkg::OP_QUERY, KB'($urandom));
    drain();
    send_hold = 1'b0;
    write_dup_mode(1'b1);
    random_phase(110, 46, 0);
    random_phase(110, 0, 46);
    write_dup_mode(1'b0);
    random_phase(110, 23, 23);

    if (!failed) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
